[hdl/b2a_pkg.sv]
package b2a_pkg;

    // Field widths
    localparam int VALUE_W = 17;
    localparam int CHAR_W  = 6;
    localparam int COUNT_W = 4;
    localparam int PC_W    = 3;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

    // Decimal places, also the digit select of a control word
    localparam logic [1:0] PLACE_TTH = 2'd0;
    localparam logic [1:0] PLACE_THO = 2'd1;
    localparam logic [1:0] PLACE_HUN = 2'd2;
    localparam logic [1:0] PLACE_TEN = 2'd3;

    // Program steps
    localparam logic [PC_W-1:0] STEP_TTH   = 3'd0;
    localparam logic [PC_W-1:0] STEP_THO   = 3'd1;
    localparam logic [PC_W-1:0] STEP_HUN   = 3'd2;
    localparam logic [PC_W-1:0] STEP_TEN   = 3'd3;
    localparam logic [PC_W-1:0] STEP_UNITS = 3'd4;

    // One control word.
    // sub_loop : subtract the place weight while the remainder allows,
    //            jumping to target; otherwise store the count and fall through
    // last     : final step, units digit from the remainder, end of beat
    typedef struct packed {
        logic                sub_loop;
        logic [1:0]          place;
        logic [PC_W-1:0]     target;
        logic                last;
    } ctrl_word_t;

    function automatic logic [VALUE_W-1:0] place_weight(input logic [1:0] place);
        logic [VALUE_W-1:0] w;
        unique case (place)
            PLACE_TTH: w = 17'd10000;
            PLACE_THO: w = 17'd1000;
            PLACE_HUN: w = 17'd100;
            PLACE_TEN: w = 17'd10;
            default:   w = 17'd10;
        endcase
        return w;
    endfunction

endpackage

[hdl/b2a_rom.sv]
module b2a_rom
    import b2a_pkg::*;
(
    input  logic [PC_W-1:0] pc,
    output ctrl_word_t      ctrl
);

    // Control store: one subtract loop per place, then the units step
    always_comb
    begin
        unique case (pc)
            STEP_TTH:   ctrl = '{sub_loop: 1'b1, place: PLACE_TTH, target: STEP_TTH, last: 1'b0};
            STEP_THO:   ctrl = '{sub_loop: 1'b1, place: PLACE_THO, target: STEP_THO, last: 1'b0};
            STEP_HUN:   ctrl = '{sub_loop: 1'b1, place: PLACE_HUN, target: STEP_HUN, last: 1'b0};
            STEP_TEN:   ctrl = '{sub_loop: 1'b1, place: PLACE_TEN, target: STEP_TEN, last: 1'b0};
            STEP_UNITS: ctrl = '{sub_loop: 1'b0, place: PLACE_TEN, target: STEP_TTH, last: 1'b1};
            default:    ctrl = '{sub_loop: 1'b0, place: PLACE_TEN, target: STEP_TTH, last: 1'b1};
        endcase
    end

endmodule

[hdl/b2a_datapath.sv]
module b2a_datapath
    import b2a_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic               active,
    input  logic [VALUE_W-1:0] value,
    input  ctrl_word_t         ctrl,
    output logic               ge,
    output logic [CHAR_W-1:0]  ten_thousands_char,
    output logic [CHAR_W-1:0]  thousands_char,
    output logic [CHAR_W-1:0]  hundreds_char,
    output logic [CHAR_W-1:0]  tens_char,
    output logic [CHAR_W-1:0]  units_char
);

    logic [VALUE_W-1:0] rest_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [CHAR_W-1:0]  tth_reg;
    logic [CHAR_W-1:0]  tho_reg;
    logic [CHAR_W-1:0]  hun_reg;
    logic [CHAR_W-1:0]  ten_reg;
    logic [CHAR_W-1:0]  uni_reg;
    logic [VALUE_W-1:0] weight;
    logic [CHAR_W-1:0]  count_char;

    // Weight compare
    assign weight     = place_weight(ctrl.place);
    assign ge         = (rest_reg >= weight);
    assign count_char = {{(CHAR_W-COUNT_W){1'b0}}, count_reg} + ASCII_ZERO;

    // Remainder and place counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (load)
        begin
            count_reg <= '0;
        end
        else if (active && ctrl.sub_loop)
        begin
            if (ge)
                count_reg <= count_reg + 1'b1;
            else
                count_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            rest_reg <= value;
        else if (active && ctrl.sub_loop && ge)
            rest_reg <= rest_reg - weight;
    end

    // Character registers, written as each place completes
    always_ff @(posedge clk)
    begin
        if (active && ctrl.sub_loop && !ge)
        begin
            unique case (ctrl.place)
                PLACE_TTH: tth_reg <= count_char;
                PLACE_THO: tho_reg <= count_char;
                PLACE_HUN: hun_reg <= count_char;
                PLACE_TEN: ten_reg <= count_char;
                default:   ten_reg <= count_char;
            endcase
        end
        if (active && !ctrl.sub_loop)
            uni_reg <= rest_reg[CHAR_W-1:0] + ASCII_ZERO;
    end

    assign ten_thousands_char = tth_reg;
    assign thousands_char     = tho_reg;
    assign hundreds_char      = hun_reg;
    assign tens_char          = ten_reg;
    assign units_char         = uni_reg;

endmodule

[hdl/binary_to_ascii_decimal_core.sv]
// Binary to ASCII decimal converter, five places.
//
// Command channel: drive value and raise start; the beat is taken at a
// rising edge where start is high and busy is low. busy stays high while
// the conversion runs and further starts are ignored.
// Result channel: done pulses for one cycle with the five characters on
// ten_thousands_char .. units_char. The receiver cannot stall; the
// characters must be captured in that cycle.
// Operation: a microcoded sequencer steps a four-entry subtract loop and a
// units step. Each place repeats its subtract step once per count and then
// stores its digit; the units step comes last, so busy grows with the sum
// of the upper four counts, and done follows the last busy cycle. The
// subtract unit does one compare and subtract per cycle.
// Values above 99999 give a ten-thousands character past '9', up to '='.
// Reset clears busy, done and the step counter; no clearing pass is needed.
module binary_to_ascii_decimal_core
    import b2a_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] value,
    output logic               done,
    output logic [CHAR_W-1:0]  ten_thousands_char,
    output logic [CHAR_W-1:0]  thousands_char,
    output logic [CHAR_W-1:0]  hundreds_char,
    output logic [CHAR_W-1:0]  tens_char,
    output logic [CHAR_W-1:0]  units_char
);

    logic            busy_reg;
    logic            busy_next;
    logic            done_reg;
    logic            done_next;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            load;
    logic            ge;
    ctrl_word_t      ctrl;

    assign load = start && !busy_reg;

    b2a_rom u_rom (
        .pc   (pc_reg),
        .ctrl (ctrl)
    );

    b2a_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .load               (load),
        .active             (busy_reg),
        .value              (value),
        .ctrl               (ctrl),
        .ge                 (ge),
        .ten_thousands_char (ten_thousands_char),
        .thousands_char     (thousands_char),
        .hundreds_char      (hundreds_char),
        .tens_char          (tens_char),
        .units_char         (units_char)
    );

    // Sequencer: step counter with conditional jump
    always_comb
    begin
        busy_next = busy_reg;
        pc_next   = pc_reg;
        done_next = 1'b0;
        priority if (load)
        begin
            busy_next = 1'b1;
            pc_next   = STEP_TTH;
        end
        else if (busy_reg)
        begin
            priority if (ctrl.sub_loop && ge)
            begin
                pc_next = ctrl.target;
            end
            else if (ctrl.last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                pc_next   = STEP_TTH;
            end
            else
            begin
                pc_next = pc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pc_reg   <= STEP_TTH;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            pc_reg   <= pc_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

[hdl/b2a_checker.sv]
module b2a_checker
    import b2a_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [VALUE_W-1:0] value,
    input  logic               done,
    input  logic [CHAR_W-1:0]  ten_thousands_char,
    input  logic [CHAR_W-1:0]  thousands_char,
    input  logic [CHAR_W-1:0]  hundreds_char,
    input  logic [CHAR_W-1:0]  tens_char,
    input  logic [CHAR_W-1:0]  units_char
);

    // An accepted beat starts a conversion
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted beat did not raise busy");

    // busy ends exactly when a result is presented
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && !$past(done))
        else $error("result strobe while busy or repeated");

    // Characters are in range on every result beat
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ten_thousands_char >= 6'h30 && ten_thousands_char <= 6'h3D
              && thousands_char >= 6'h30 && thousands_char <= 6'h39
              && hundreds_char >= 6'h30 && hundreds_char <= 6'h39
              && tens_char >= 6'h30 && tens_char <= 6'h39
              && units_char >= 6'h30 && units_char <= 6'h39)
        else $error("result character out of range");

    // Value zero takes the shortest run and comes back as all zero characters
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && value == '0 |-> ##6 done
            && ten_thousands_char == ASCII_ZERO && thousands_char == ASCII_ZERO
            && hundreds_char == ASCII_ZERO && tens_char == ASCII_ZERO
            && units_char == ASCII_ZERO)
        else $error("zero value did not give all zero characters");

endmodule

bind binary_to_ascii_decimal_core b2a_checker u_b2a_checker (.*);
